FILE: rtl/marching_cubes_cell_extractor_macros.svh
// ----------------------------------------------------------------------------
// marching_cubes_cell_extractor_macros
// assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef MARCHING_CUBES_CELL_EXTRACTOR_MACROS_SVH
`define MARCHING_CUBES_CELL_EXTRACTOR_MACROS_SVH

// condition must hold whenever the enable is high
`define MCE_ASSERT_IMPL(lbl, clk, rst_n, en, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (en) |-> (cond)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define MCE_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: rtl/mce_pkg.sv
// ----------------------------------------------------------------------------
// mce_pkg
// shared types, constants and case tables of the cell extractor
// ----------------------------------------------------------------------------
package mce_pkg;

    localparam int unsigned MaxGridDim = 1024;
    localparam int unsigned SampleBits = 16;
    localparam int unsigned PhiBits    = SampleBits + 1;
    localparam int unsigned RowBits    = 60;

    typedef enum logic [1:0] {
        CFG_ISO_LEVEL   = 2'd0,
        CFG_GRID_SIZE_X = 2'd1,
        CFG_GRID_SIZE_Y = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SETUP,
        B_DIV,
        B_EMIT
    } t_back_state;

    // one classified cell waiting for the back end
    typedef struct packed {
        logic [9:0]                     cx;
        logic [9:0]                     cy;
        logic [9:0]                     cz;
        logic [7:0][PhiBits-1:0]        phi;
        logic [3:0]                     cnt;
        logic [RowBits-1:0]             row;
    } t_cell;

    // queue status between front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // edge end corners {first, second}
    function automatic logic [5:0] edge_ends(input logic [3:0] e);
        logic [5:0] r;
        case (e)
            4'd0:    r = {3'd0, 3'd1};
            4'd1:    r = {3'd1, 3'd2};
            4'd2:    r = {3'd2, 3'd3};
            4'd3:    r = {3'd3, 3'd0};
            4'd4:    r = {3'd4, 3'd5};
            4'd5:    r = {3'd5, 3'd6};
            4'd6:    r = {3'd6, 3'd7};
            4'd7:    r = {3'd7, 3'd4};
            4'd8:    r = {3'd0, 3'd4};
            4'd9:    r = {3'd1, 3'd5};
            4'd10:   r = {3'd2, 3'd6};
            4'd11:   r = {3'd3, 3'd7};
            default: r = {3'd0, 3'd1};
        endcase
        return r;
    endfunction

    // edge midpoint on the doubled grid {oz, oy, ox}
    function automatic logic [5:0] edge_mid(input logic [3:0] e);
        logic [5:0] r;
        case (e)
            4'd0:    r = {2'd0, 2'd0, 2'd1};
            4'd1:    r = {2'd1, 2'd0, 2'd2};
            4'd2:    r = {2'd2, 2'd0, 2'd1};
            4'd3:    r = {2'd1, 2'd0, 2'd0};
            4'd4:    r = {2'd0, 2'd2, 2'd1};
            4'd5:    r = {2'd1, 2'd2, 2'd2};
            4'd6:    r = {2'd2, 2'd2, 2'd1};
            4'd7:    r = {2'd1, 2'd2, 2'd0};
            4'd8:    r = {2'd0, 2'd1, 2'd0};
            4'd9:    r = {2'd0, 2'd1, 2'd2};
            4'd10:   r = {2'd2, 2'd1, 2'd2};
            4'd11:   r = {2'd2, 2'd1, 2'd0};
            default: r = {2'd0, 2'd0, 2'd1};
        endcase
        return r;
    endfunction

    // triangle list per case: {vertex count, edges}, first edge in the top used nibble
    function automatic logic [RowBits+3:0] tri_row(input logic [7:0] c);
        logic [RowBits+3:0] r;
        case (c)
            8'd0: r = {4'd0, 60'h0};  8'd1: r = {4'd3, 60'h083};
            8'd2: r = {4'd3, 60'h019};  8'd3: r = {4'd6, 60'h183981};
            8'd4: r = {4'd3, 60'h12a};  8'd5: r = {4'd6, 60'h08312a};
            8'd6: r = {4'd6, 60'h92a029};  8'd7: r = {4'd9, 60'h2832a8a98};
            8'd8: r = {4'd3, 60'h3b2};  8'd9: r = {4'd6, 60'h0b28b0};
            8'd10: r = {4'd6, 60'h19023b};  8'd11: r = {4'd9, 60'h1b219b98b};
            8'd12: r = {4'd6, 60'h3a1ba3};  8'd13: r = {4'd9, 60'h0a108a8ba};
            8'd14: r = {4'd9, 60'h3903b9ba9};  8'd15: r = {4'd6, 60'h98aa8b};
            8'd16: r = {4'd3, 60'h478};  8'd17: r = {4'd6, 60'h430734};
            8'd18: r = {4'd6, 60'h019847};  8'd19: r = {4'd9, 60'h419471731};
            8'd20: r = {4'd6, 60'h12a847};  8'd21: r = {4'd9, 60'h34730412a};
            8'd22: r = {4'd9, 60'h92a902847};  8'd23: r = {4'd12, 60'h2a9297273794};
            8'd24: r = {4'd6, 60'h8473b2};  8'd25: r = {4'd9, 60'hb47b24204};
            8'd26: r = {4'd9, 60'h90184723b};  8'd27: r = {4'd12, 60'h47b94b9b2921};
            8'd28: r = {4'd9, 60'h3a13ba784};  8'd29: r = {4'd12, 60'h1ba14b1047b4};
            8'd30: r = {4'd12, 60'h47890b9bab03};  8'd31: r = {4'd9, 60'h47b4b99ba};
            8'd32: r = {4'd3, 60'h954};  8'd33: r = {4'd6, 60'h954083};
            8'd34: r = {4'd6, 60'h054150};  8'd35: r = {4'd9, 60'h854835315};
            8'd36: r = {4'd6, 60'h12a954};  8'd37: r = {4'd9, 60'h30812a495};
            8'd38: r = {4'd9, 60'h52a542402};  8'd39: r = {4'd12, 60'h2a5325354348};
            8'd40: r = {4'd6, 60'h95423b};  8'd41: r = {4'd9, 60'h0b208b495};
            8'd42: r = {4'd9, 60'h05401523b};  8'd43: r = {4'd12, 60'h21525828b485};
            8'd44: r = {4'd9, 60'ha3ba13954};  8'd45: r = {4'd12, 60'h4950818a18ba};
            8'd46: r = {4'd12, 60'h54050b5bab03};  8'd47: r = {4'd9, 60'h54858aa8b};
            8'd48: r = {4'd6, 60'h978579};  8'd49: r = {4'd9, 60'h930953573};
            8'd50: r = {4'd9, 60'h078017157};  8'd51: r = {4'd6, 60'h153357};
            8'd52: r = {4'd9, 60'h978957a12};  8'd53: r = {4'd12, 60'ha12950530573};
            8'd54: r = {4'd12, 60'h802825857a52};  8'd55: r = {4'd9, 60'h2a5253357};
            8'd56: r = {4'd9, 60'h7957893b2};  8'd57: r = {4'd12, 60'h95797292027b};
            8'd58: r = {4'd12, 60'h23b018178157};  8'd59: r = {4'd9, 60'hb21b17715};
            8'd60: r = {4'd12, 60'h958857a13a3b};  8'd61: r = {4'd15, 60'h5705097b010aba0};
            8'd62: r = {4'd15, 60'hba0b03a50807570};  8'd63: r = {4'd6, 60'hba57b5};
            8'd64: r = {4'd3, 60'ha65};  8'd65: r = {4'd6, 60'h0835a6};
            8'd66: r = {4'd6, 60'h9015a6};  8'd67: r = {4'd9, 60'h1831985a6};
            8'd68: r = {4'd6, 60'h165261};  8'd69: r = {4'd9, 60'h165126308};
            8'd70: r = {4'd9, 60'h965906026};  8'd71: r = {4'd12, 60'h598582526328};
            8'd72: r = {4'd6, 60'h23ba65};  8'd73: r = {4'd9, 60'hb08b20a65};
            8'd74: r = {4'd9, 60'h01923b5a6};  8'd75: r = {4'd12, 60'h5a61929b298b};
            8'd76: r = {4'd9, 60'h63b653513};  8'd77: r = {4'd12, 60'h08b0b50515b6};
            8'd78: r = {4'd12, 60'h3b6036065059};  8'd79: r = {4'd9, 60'h65969bb98};
            8'd80: r = {4'd6, 60'h5a6478};  8'd81: r = {4'd9, 60'h43047365a};
            8'd82: r = {4'd9, 60'h1905a6847};  8'd83: r = {4'd12, 60'ha65197173794};
            8'd84: r = {4'd9, 60'h612651478};  8'd85: r = {4'd12, 60'h125526304347};
            8'd86: r = {4'd12, 60'h847905065026};  8'd87: r = {4'd15, 60'h739794329596269};
            8'd88: r = {4'd9, 60'h3b2784a65};  8'd89: r = {4'd12, 60'h5a647242027b};
            8'd90: r = {4'd12, 60'h01947823b5a6};  8'd91: r = {4'd15, 60'h9219b294b7b45a6};
            8'd92: r = {4'd12, 60'h8473b53515b6};  8'd93: r = {4'd15, 60'h51b5b610b7b404b};
            8'd94: r = {4'd15, 60'h059065036b63847};  8'd95: r = {4'd12, 60'h65969b4797b9};
            8'd96: r = {4'd6, 60'ha4964a};  8'd97: r = {4'd9, 60'h4a649a083};
            8'd98: r = {4'd9, 60'ha01a60640};  8'd99: r = {4'd12, 60'h83181686461a};
            8'd100: r = {4'd9, 60'h149124264};  8'd101: r = {4'd12, 60'h308129249264};
            8'd102: r = {4'd6, 60'h024426};  8'd103: r = {4'd9, 60'h832824426};
            8'd104: r = {4'd9, 60'ha49a64b23};  8'd105: r = {4'd12, 60'h08228b49a4a6};
            8'd106: r = {4'd12, 60'h3b201606461a};  8'd107: r = {4'd15, 60'h64161a48121b8b1};
            8'd108: r = {4'd12, 60'h964936913b63};  8'd109: r = {4'd15, 60'h8b1810b61914641};
            8'd110: r = {4'd9, 60'h3b6360064};  8'd111: r = {4'd6, 60'h648b68};
            8'd112: r = {4'd9, 60'h7a678a89a};  8'd113: r = {4'd12, 60'h0730a709a67a};
            8'd114: r = {4'd12, 60'ha671a7178180};  8'd115: r = {4'd9, 60'ha67a71173};
            8'd116: r = {4'd12, 60'h126168189867};  8'd117: r = {4'd15, 60'h269291679093739};
            8'd118: r = {4'd9, 60'h780706602};  8'd119: r = {4'd6, 60'h732672};
            8'd120: r = {4'd12, 60'h23ba68a89867};  8'd121: r = {4'd15, 60'h20727b09767a9a7};
            8'd122: r = {4'd15, 60'h1801781a767a23b};  8'd123: r = {4'd12, 60'hb21b17a61671};
            8'd124: r = {4'd15, 60'h896867916b63136};  8'd125: r = {4'd6, 60'h091b67};
            8'd126: r = {4'd12, 60'h7807063b0b60};  8'd127: r = {4'd3, 60'h7b6};
            8'd128: r = {4'd3, 60'h76b};  8'd129: r = {4'd6, 60'h308b76};
            8'd130: r = {4'd6, 60'h019b76};  8'd131: r = {4'd9, 60'h819831b76};
            8'd132: r = {4'd6, 60'ha126b7};  8'd133: r = {4'd9, 60'h12a3086b7};
            8'd134: r = {4'd9, 60'h2902a96b7};  8'd135: r = {4'd12, 60'h6b72a3a83a98};
            8'd136: r = {4'd6, 60'h723627};  8'd137: r = {4'd9, 60'h708760620};
            8'd138: r = {4'd9, 60'h276237019};  8'd139: r = {4'd12, 60'h162186198876};
            8'd140: r = {4'd9, 60'ha76a17137};  8'd141: r = {4'd12, 60'ha7617a187108};
            8'd142: r = {4'd12, 60'h03707a0a96a7};  8'd143: r = {4'd9, 60'h76a7a88a9};
            8'd144: r = {4'd6, 60'h684b86};  8'd145: r = {4'd9, 60'h36b306046};
            8'd146: r = {4'd9, 60'h86b846901};  8'd147: r = {4'd12, 60'h946963931b36};
            8'd148: r = {4'd9, 60'h6846b82a1};  8'd149: r = {4'd12, 60'h12a30b06b046};
            8'd150: r = {4'd12, 60'h4b846b0292a9};  8'd151: r = {4'd15, 60'ha93a32943b36463};
            8'd152: r = {4'd9, 60'h823842462};  8'd153: r = {4'd6, 60'h042462};
            8'd154: r = {4'd12, 60'h190234246438};  8'd155: r = {4'd9, 60'h194142246};
            8'd156: r = {4'd12, 60'h8138618466a1};  8'd157: r = {4'd9, 60'ha10a06604};
            8'd158: r = {4'd15, 60'h4634386a3039a93};  8'd159: r = {4'd6, 60'ha946a4};
            8'd160: r = {4'd6, 60'h49576b};  8'd161: r = {4'd9, 60'h083495b76};
            8'd162: r = {4'd9, 60'h50154076b};  8'd163: r = {4'd12, 60'hb76834354315};
            8'd164: r = {4'd9, 60'h954a1276b};  8'd165: r = {4'd12, 60'h6b712a083495};
            8'd166: r = {4'd12, 60'h76b54a42a402};  8'd167: r = {4'd15, 60'h348354325a52b76};
            8'd168: r = {4'd9, 60'h723762549};  8'd169: r = {4'd12, 60'h954086062687};
            8'd170: r = {4'd12, 60'h362376150540};  8'd171: r = {4'd15, 60'h628687218485158};
            8'd172: r = {4'd12, 60'h954a16176137};  8'd173: r = {4'd15, 60'h16a176107870954};
            8'd174: r = {4'd15, 60'h40a4a503a6a737a};  8'd175: r = {4'd12, 60'h76a7a854a48a};
            8'd176: r = {4'd9, 60'h6956b9b89};  8'd177: r = {4'd12, 60'h36b063056095};
            8'd178: r = {4'd12, 60'h0b805b01556b};  8'd179: r = {4'd9, 60'h6b3635531};
            8'd180: r = {4'd12, 60'h12a95b9b8b56};  8'd181: r = {4'd15, 60'h0b306b09656912a};
            8'd182: r = {4'd15, 60'hb85b56805a52025};  8'd183: r = {4'd12, 60'h6b36352a3a53};
            8'd184: r = {4'd12, 60'h589528562382};  8'd185: r = {4'd9, 60'h956960062};
            8'd186: r = {4'd15, 60'h158180568382628};  8'd187: r = {4'd6, 60'h156216};
            8'd188: r = {4'd15, 60'h13616a386569896};  8'd189: r = {4'd12, 60'ha10a06950560};
            8'd190: r = {4'd6, 60'h03856a};  8'd191: r = {4'd3, 60'ha56};
            8'd192: r = {4'd6, 60'hb5a75b};  8'd193: r = {4'd9, 60'hb5ab75830};
            8'd194: r = {4'd9, 60'h5b75ab190};  8'd195: r = {4'd12, 60'ha75ab7981831};
            8'd196: r = {4'd9, 60'hb12b71751};  8'd197: r = {4'd12, 60'h08312717572b};
            8'd198: r = {4'd12, 60'h9759279022b7};  8'd199: r = {4'd15, 60'h75272b592328982};
            8'd200: r = {4'd9, 60'h25a235375};  8'd201: r = {4'd12, 60'h820852875a25};
            8'd202: r = {4'd12, 60'h9015a35373a2};  8'd203: r = {4'd15, 60'h982921872a25752};
            8'd204: r = {4'd6, 60'h135375};  8'd205: r = {4'd9, 60'h087071175};
            8'd206: r = {4'd9, 60'h903935537};  8'd207: r = {4'd6, 60'h987597};
            8'd208: r = {4'd9, 60'h5845a8ab8};  8'd209: r = {4'd12, 60'h5045b05abb30};
            8'd210: r = {4'd12, 60'h01984a8aba45};  8'd211: r = {4'd15, 60'hab4a45b34941314};
            8'd212: r = {4'd12, 60'h2512852b8458};  8'd213: r = {4'd15, 60'h04b0b345b2b151b};
            8'd214: r = {4'd15, 60'h0250592b5458b85};  8'd215: r = {4'd6, 60'h9452b3};
            8'd216: r = {4'd12, 60'h25a352345384};  8'd217: r = {4'd9, 60'h5a2524420};
            8'd218: r = {4'd15, 60'h3a235a385458019};  8'd219: r = {4'd12, 60'h5a2524192942};
            8'd220: r = {4'd9, 60'h845853351};  8'd221: r = {4'd6, 60'h045105};
            8'd222: r = {4'd12, 60'h845853905035};  8'd223: r = {4'd3, 60'h945};
            8'd224: r = {4'd9, 60'h4b749b9ab};  8'd225: r = {4'd12, 60'h0834979b79ab};
            8'd226: r = {4'd12, 60'h1ab1b414074b};  8'd227: r = {4'd15, 60'h3143481a474bab4};
            8'd228: r = {4'd12, 60'h4b79b492b912};  8'd229: r = {4'd15, 60'h9749b791b2b1083};
            8'd230: r = {4'd9, 60'hb74b42240};  8'd231: r = {4'd12, 60'hb74b42834324};
            8'd232: r = {4'd12, 60'h29a279237749};  8'd233: r = {4'd15, 60'h9a7974a27870207};
            8'd234: r = {4'd15, 60'h37a3a274a1a040a};  8'd235: r = {4'd6, 60'h1a2874};
            8'd236: r = {4'd9, 60'h491417713};  8'd237: r = {4'd12, 60'h491417081871};
            8'd238: r = {4'd6, 60'h403743};  8'd239: r = {4'd3, 60'h487};
            8'd240: r = {4'd6, 60'h9a8ab8};  8'd241: r = {4'd9, 60'h30939bb9a};
            8'd242: r = {4'd9, 60'h01a0a88ab};  8'd243: r = {4'd6, 60'h31ab3a};
            8'd244: r = {4'd9, 60'h12b1b99b8};  8'd245: r = {4'd12, 60'h30939b1292b9};
            8'd246: r = {4'd6, 60'h02b80b};  8'd247: r = {4'd3, 60'h32b};
            8'd248: r = {4'd9, 60'h23828aa89};  8'd249: r = {4'd6, 60'h9a2092};
            8'd250: r = {4'd12, 60'h23828a0181a8};  8'd251: r = {4'd3, 60'h1a2};
            8'd252: r = {4'd6, 60'h138918};  8'd253: r = {4'd3, 60'h091};
            8'd254: r = {4'd3, 60'h038};
            default: r = {4'd0, 60'h0};
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/mce_front.sv
// ----------------------------------------------------------------------------
// mce_front
// classifies a cell against the iso level and looks up its triangle list
// ----------------------------------------------------------------------------
module mce_front import mce_pkg::*; (
    input  logic [9:0]              i_cell_x,
    input  logic [9:0]              i_cell_y,
    input  logic [9:0]              i_cell_z,
    input  logic [7:0][15:0]        i_corner,
    input  logic [15:0]             i_iso_level,
    output t_cell                   o_cell,
    output logic                    o_has_tris
);

    logic [7:0]          cube;
    logic [RowBits+3:0]  tri_entry;

    always_comb begin
        o_cell.cx = i_cell_x;
        o_cell.cy = i_cell_y;
        o_cell.cz = i_cell_z;
        for (int k = 0; k < 8; k++) begin
            o_cell.phi[k] = PhiBits'($signed({i_corner[k][15], i_corner[k]})
                                   - $signed({i_iso_level[15], i_iso_level}));
            // at or below the level counts as inside
            cube[k] = o_cell.phi[k][PhiBits-1] || (o_cell.phi[k] == '0);
        end
        tri_entry   = tri_row(cube);
        o_cell.cnt  = tri_entry[RowBits+3:RowBits];
        o_cell.row  = tri_entry[RowBits-1:0];
        o_has_tris  = (o_cell.cnt != 4'd0);
    end

endmodule

FILE: rtl/mce_queue.sv
// ----------------------------------------------------------------------------
// mce_queue
// two-entry queue of classified cells between front and back
// ----------------------------------------------------------------------------
module mce_queue import mce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr,
    input  t_cell       i_data,
    input  logic        i_rd,
    output t_cell       o_data,
    output t_q_status   o_status
);

    t_cell       r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wptr <= ~r_wptr;
            end
            if (i_rd) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, i_wr} - {1'b0, i_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rptr];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

endmodule

FILE: rtl/mce_back.sv
// ----------------------------------------------------------------------------
// mce_back
// walks a cell's triangle list: edge id, crossing fraction, one vertex at a time
// ----------------------------------------------------------------------------
module mce_back import mce_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cell        i_cell,
    input  t_q_status    i_q_status,
    output logic         o_q_rd,
    input  logic [10:0]  i_grid_size_x,
    input  logic [10:0]  i_grid_size_y,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [3:0]   o_local_edge,
    output logic [32:0]  o_global_edge_id,
    output logic [15:0]  o_edge_fraction,
    output logic [2:0]   o_triangle_index,
    output logic         o_last_vertex
);

    t_back_state  r_state, n_state;
    logic [3:0]   r_n;
    logic [2:0]   r_tri;
    logic [1:0]   r_k;
    logic [3:0]   r_edge;
    logic [24:0]  r_t1;
    logic [32:0]  r_id;
    logic [16:0]  r_s;
    logic [16:0]  r_rem;
    logic [16:0]  r_q;
    logic [3:0]   r_step;
    logic         r_ov;

    logic [3:0]        pos;
    logic [3:0]        edge_sel;
    logic [5:0]        ends;
    logic [5:0]        mid;
    logic [PhiBits-1:0] p0, p1;
    logic [15:0]       a, b;
    logic [16:0]       s;
    logic [10:0]       gx, gy;
    logic [5:0]        mid_r;
    logic [17:0]       rem2;
    logic              take;
    logic              slot_free;
    logic              last;
    logic [15:0]       frac;

    assign gx = (i_grid_size_x > 11'(MaxGridDim)) ? 11'(MaxGridDim) : i_grid_size_x;
    assign gy = (i_grid_size_y > 11'(MaxGridDim)) ? 11'(MaxGridDim) : i_grid_size_y;

    always_comb begin
        pos      = i_cell.cnt - 4'd1 - r_n;
        edge_sel = i_cell.row[{pos, 2'b00} +: 4];
        ends     = edge_ends(edge_sel);
        mid      = edge_mid(edge_sel);
        p0       = i_cell.phi[ends[5:3]];
        p1       = i_cell.phi[ends[2:0]];
        a        = 16'(p0[PhiBits-1] ? -p0 : p0);
        b        = 16'(p1[PhiBits-1] ? -p1 : p1);
        s        = {1'b0, a} + {1'b0, b};
        mid_r    = edge_mid(r_edge);
        rem2     = {r_rem, 1'b0};
        take     = (rem2 >= {1'b0, r_s});
        last     = (r_n == i_cell.cnt - 4'd1);
        slot_free = !r_ov || i_pop;
        if (r_s == 17'd0) begin
            frac = 16'd32768;
        end else if (r_q == 17'd0) begin
            frac = 16'd1;
        end else if (r_q[16]) begin
            frac = 16'hffff;
        end else begin
            frac = r_q[15:0];
        end
    end

    always_comb begin
        n_state = r_state;
        o_q_rd  = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = B_SETUP;
                end
            end
            B_SETUP: n_state = B_DIV;
            B_DIV: begin
                if (r_step == 4'd15) begin
                    n_state = B_EMIT;
                end
            end
            B_EMIT: begin
                if (slot_free) begin
                    o_q_rd  = last;
                    n_state = last ? B_IDLE : B_SETUP;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_n     <= 4'd0;
            r_tri   <= 3'd0;
            r_k     <= 2'd0;
            r_step  <= 4'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            // a new vertex replacing the popped one keeps the slot full
            if (i_pop && !(r_state == B_EMIT && slot_free)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    r_n   <= 4'd0;
                    r_tri <= 3'd0;
                    r_k   <= 2'd0;
                end
                B_SETUP: r_step <= 4'd0;
                B_DIV:   r_step <= r_step + 4'd1;
                B_EMIT: begin
                    if (slot_free) begin
                        r_ov <= 1'b1;
                        r_n  <= r_n + 4'd1;
                        if (r_k == 2'd2) begin
                            r_k   <= 2'd0;
                            r_tri <= r_tri + 3'd1;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath: restoring divide, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_SETUP: begin
                r_edge <= edge_sel;
                r_s    <= s;
                r_q    <= {(b == 16'd0), 16'd0};
                r_rem  <= (b == 16'd0) ? 17'd0 : {1'b0, a};
                r_t1   <= 25'({1'b0, i_cell.cz, 1'b0} + 12'(mid[5:4])) * 25'({gy, 1'b0})
                        + 25'({1'b0, i_cell.cy, 1'b0} + 12'(mid[3:2]));
            end
            B_DIV: begin
                r_rem <= take ? 17'(rem2 - {1'b0, r_s}) : r_rem << 1;
                r_q   <= {r_q[16], r_q[14:0], take};
                if (r_step == 4'd0) begin
                    r_id <= 33'(r_t1 * 37'({gx, 1'b0}))
                          + 33'({1'b0, i_cell.cx, 1'b0} + 12'(mid_r[1:0]));
                end
            end
            B_EMIT: begin
                if (slot_free) begin
                    o_local_edge     <= r_edge;
                    o_global_edge_id <= r_id;
                    o_edge_fraction  <= frac;
                    o_triangle_index <= r_tri;
                    o_last_vertex    <= last;
                end
            end
            default: ;
        endcase
    end

    assign o_empty = !r_ov;

endmodule

FILE: rtl/marching_cubes_cell_extractor.sv
// ----------------------------------------------------------------------------
// marching_cubes_cell_extractor
// emits the triangle vertices of one grid cell per input transaction
// ----------------------------------------------------------------------------
// usage:
//   input queue: drive a cell on the i_ ports and raise i_push; the cell is
//   taken when o_full is low. the front classifies it in the same cycle and
//   drops cells with all corners inside or all outside.
//   result queue: while o_empty is low one vertex is on the o_ ports; raise
//   i_pop to take it. vertices come in triangle-list order and o_last_vertex
//   marks the last vertex of a cell.
//   config: write iso level / grid sizes with i_cfg_valid, i_cfg_index and
//   i_cfg_data while idle; o_cfg_ready is always high.
// back end: each vertex passes through setup, a 16-step restoring divider
//   for the crossing fraction, and emit; each cell of 3 to 15 vertices
//   also passes through an idle state. a two-entry cell queue lets the
//   front keep taking cells while the back works.
// reset: synchronous, clears queues and control; registers return to iso 0
//   and grid 1024 x 1024. a stalled result holds and stalls the back end.
// ----------------------------------------------------------------------------
module marching_cubes_cell_extractor import mce_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_full,
    input  logic [9:0]   i_cell_x,
    input  logic [9:0]   i_cell_y,
    input  logic [9:0]   i_cell_z,
    input  logic [15:0]  i_corner_value_0,
    input  logic [15:0]  i_corner_value_1,
    input  logic [15:0]  i_corner_value_2,
    input  logic [15:0]  i_corner_value_3,
    input  logic [15:0]  i_corner_value_4,
    input  logic [15:0]  i_corner_value_5,
    input  logic [15:0]  i_corner_value_6,
    input  logic [15:0]  i_corner_value_7,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    output logic         o_empty,
    input  logic         i_pop,
    output logic [3:0]   o_local_edge,
    output logic [32:0]  o_global_edge_id,
    output logic [15:0]  o_edge_fraction,
    output logic [2:0]   o_triangle_index,
    output logic         o_last_vertex
);

`include "marching_cubes_cell_extractor_macros.svh"

    // configuration registers
    logic [15:0]  r_iso_level;
    logic [10:0]  r_grid_size_x;
    logic [10:0]  r_grid_size_y;

    logic [7:0][15:0]  corners;
    t_cell             front_cell;
    t_cell             head_cell;
    logic              has_tris;
    logic              accept;
    logic              q_rd;
    logic              pop_ok;
    t_q_status         q_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iso_level   <= 16'd0;
            r_grid_size_x <= 11'(MaxGridDim);
            r_grid_size_y <= 11'(MaxGridDim);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ISO_LEVEL:   r_iso_level   <= i_cfg_data;
                CFG_GRID_SIZE_X: r_grid_size_x <= i_cfg_data[10:0];
                CFG_GRID_SIZE_Y: r_grid_size_y <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    assign corners = {i_corner_value_7, i_corner_value_6, i_corner_value_5,
                      i_corner_value_4, i_corner_value_3, i_corner_value_2,
                      i_corner_value_1, i_corner_value_0};

    assign o_full = q_status.full;
    assign accept = i_push && !q_status.full;
    assign pop_ok = i_pop && !o_empty;

    mce_front u_front (
        .i_cell_x    (i_cell_x),
        .i_cell_y    (i_cell_y),
        .i_cell_z    (i_cell_z),
        .i_corner    (corners),
        .i_iso_level (r_iso_level),
        .o_cell      (front_cell),
        .o_has_tris  (has_tris)
    );

    // only cells that cut the surface go to the back end
    mce_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (accept && has_tris),
        .i_data   (front_cell),
        .i_rd     (q_rd),
        .o_data   (head_cell),
        .o_status (q_status)
    );

    mce_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cell           (head_cell),
        .i_q_status       (q_status),
        .o_q_rd           (q_rd),
        .i_grid_size_x    (r_grid_size_x),
        .i_grid_size_y    (r_grid_size_y),
        .i_pop            (pop_ok),
        .o_empty          (o_empty),
        .o_local_edge     (o_local_edge),
        .o_global_edge_id (o_global_edge_id),
        .o_edge_fraction  (o_edge_fraction),
        .o_triangle_index (o_triangle_index),
        .o_last_vertex    (o_last_vertex)
    );

    // a waiting vertex always has a valid edge, triangle and nonzero fraction
    `MCE_ASSERT_IMPL(a_vertex_legal, i_clk, i_rst_n, !o_empty, (o_local_edge <= 4'd11) && (o_triangle_index <= 3'd4) && (o_edge_fraction != 16'd0), "illegal vertex fields")
    // the back end never reads an empty cell queue
    `MCE_ASSERT_IMPL(a_no_underrun, i_clk, i_rst_n, q_rd, !q_status.empty, "cell queue underrun")
    // a vertex left untaken is still there next cycle
    `MCE_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, !o_empty && !i_pop, !o_empty && $stable(o_global_edge_id), "result changed while stalled")

endmodule
